FILE: sv/sgm_pkg.sv
package sgm_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CFG_DW = 13;

	localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_SOBEL   = 2'd0;
	localparam logic [1:0] MODE_FELDMAN = 2'd1;
	localparam logic [1:0] MODE_SCHARR  = 2'd2;
	localparam logic [1:0] MODE_ZERO    = 2'd3;

	localparam logic [1:0]  RESET_MODE   = MODE_SOBEL;
	localparam logic [10:0] RESET_WIDTH  = 11'd512;
	localparam logic [12:0] RESET_HEIGHT = 13'd512;

	typedef struct packed {
		logic [7:0] pixel;
		logic       drain;
	} in_item_t;

	typedef struct packed {
		logic [7:0] magnitude;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] side;
		logic [7:0] center;
	} weights_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOAD   = 5'b00010,
		ST_SQUARE = 5'b00100,
		ST_ROOT   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic square;
		logic root_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic produce;
		logic root_done;
	} sts_t;

	function automatic weights_t kernel_weights(input logic [1:0] mode);
		weights_t w;
		unique case (mode)
			MODE_SOBEL: begin
				w.side = 8'd1;
				w.center = 8'd2;
			end
			MODE_FELDMAN: begin
				w.side = 8'd3;
				w.center = 8'd10;
			end
			MODE_SCHARR: begin
				w.side = 8'd47;
				w.center = 8'd162;
			end
			default: begin
				w.side = 8'd0;
				w.center = 8'd0;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: sv/sgm_ram.sv
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/sgm_ctrl.sv
module sgm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sgm_pkg::cmd_t cmd,
	input  sgm_pkg::sts_t sts
);
	import sgm_pkg::*;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_n = sts.produce ? ST_SQUARE : ST_IDLE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_n = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) state_n = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					cmd.emit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

FILE: sv/sgm_dp.sv
module sgm_dp #(
	parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sgm_pkg::in_item_t          in_data,
	output sgm_pkg::out_item_t         out_data,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [sgm_pkg::CFG_DW-1:0] wr_data,
	input  sgm_pkg::cmd_t              cmd,
	output sgm_pkg::sts_t              sts
);
	import sgm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [1:0]  mode_q;
	logic [10:0] fw_q;
	logic [12:0] fh_q;

	logic [CW:0] w_eff;
	logic [RW:0] h_eff;

	logic [CW-1:0] icol_q, col_eff, col_q;
	logic [1:0]    irow_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	logic [7:0]    v_q;
	logic [7:0]    wc_q [6];
	logic [7:0]    top_rd, mid_rd;

	logic signed [17:0] gx_q, gy_q;
	logic               last_q;
	logic [16:0]        sum_q;
	logic               sat_q;
	logic [7:0]         root_q;
	logic [2:0]         bit_q;

	logic geo_wr;
	logic lv, rv, tv, bv, last_n;
	logic [7:0] p00, p10, p20, p01, p21, p02, p12, p22;
	logic signed [9:0] dxs, dys, dxc, dyc;
	logic signed [17:0] gx_n, gy_n;
	logic [16:0] ax, ay;
	logic [7:0]  cand;
	logic [15:0] cand_sq;
	weights_t    wt;

	always_comb begin
		if (fw_q == '0) w_eff = (CW+1)'(1);
		else if (32'(fw_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(fw_q);
		if (fh_q == '0) h_eff = (RW+1)'(1);
		else if (32'(fh_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(fh_q);
	end

	assign col_eff = ({1'b0, icol_q} >= w_eff) ? '0 : icol_q;

	sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(cmd.load), .waddr(col_q), .wdata(mid_rd),
		.raddr(col_eff), .rdata(top_rd)
	);
	sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(cmd.load), .waddr(col_q), .wdata(v_q),
		.raddr(col_eff), .rdata(mid_rd)
	);

	// edge flags of the output pixel
	assign lv = (ocol_q != '0);
	assign rv = ((CW+1)'(ocol_q) + (CW+1)'(1)) != w_eff;
	assign tv = (orow_q != '0);
	assign bv = ((RW+1)'(orow_q) + (RW+1)'(1)) != h_eff;
	assign last_n = !rv && !bv;

	assign sts.produce = (irow_q == 2'd2) || ((irow_q == 2'd1) && (col_q != '0));
	assign sts.root_done = (bit_q == 3'd0);

	always_comb begin
		p00 = (lv && tv) ? wc_q[0] : 8'd0;
		p10 = lv ? wc_q[1] : 8'd0;
		p20 = (lv && bv) ? wc_q[2] : 8'd0;
		p01 = tv ? wc_q[3] : 8'd0;
		p21 = bv ? wc_q[5] : 8'd0;
		p02 = (rv && tv) ? top_rd : 8'd0;
		p12 = rv ? mid_rd : 8'd0;
		p22 = (rv && bv) ? v_q : 8'd0;
		wt  = kernel_weights(mode_q);
		dxs = $signed({2'b0, p00}) - $signed({2'b0, p02})
		    + $signed({2'b0, p20}) - $signed({2'b0, p22});
		dys = $signed({2'b0, p00}) - $signed({2'b0, p20})
		    + $signed({2'b0, p02}) - $signed({2'b0, p22});
		dxc = $signed({2'b0, p10}) - $signed({2'b0, p12});
		dyc = $signed({2'b0, p01}) - $signed({2'b0, p21});
		gx_n = 18'(dxs) * $signed({10'b0, wt.side}) + 18'(dxc) * $signed({10'b0, wt.center});
		gy_n = 18'(dys) * $signed({10'b0, wt.side}) + 18'(dyc) * $signed({10'b0, wt.center});
		ax = gx_q[17] ? 17'(-gx_q) : 17'(gx_q);
		ay = gy_q[17] ? 17'(-gy_q) : 17'(gy_q);
		cand = root_q | (8'd1 << bit_q);
		cand_sq = 16'(cand) * 16'(cand);
	end

	assign geo_wr = wr_en && ((wr_index == REG_FRAME_WIDTH) || (wr_index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RESET_MODE;
			fw_q   <= RESET_WIDTH;
			fh_q   <= RESET_HEIGHT;
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			for (int i = 0; i < 6; i++) wc_q[i] <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_KERNEL_MODE:  mode_q <= wr_data[1:0];
					REG_FRAME_WIDTH:  fw_q <= wr_data[10:0];
					REG_FRAME_HEIGHT: fh_q <= wr_data;
					default: ;
				endcase
			end
			if (geo_wr) begin
				icol_q <= '0;
				irow_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else if (cmd.load) begin
				for (int i = 0; i < 3; i++) wc_q[i] <= wc_q[i+3];
				wc_q[3] <= top_rd;
				wc_q[4] <= mid_rd;
				wc_q[5] <= v_q;
				if ((CW+1)'(col_q) + (CW+1)'(1) == w_eff) begin
					icol_q <= '0;
					if (irow_q != 2'd2) irow_q <= irow_q + 2'd1;
				end else begin
					icol_q <= col_q + CW'(1);
				end
			end else if (cmd.emit) begin
				if (out_data.last) begin
					icol_q <= '0;
					irow_q <= '0;
					ocol_q <= '0;
					orow_q <= '0;
				end else if ((CW+1)'(ocol_q) + (CW+1)'(1) == w_eff) begin
					ocol_q <= '0;
					orow_q <= orow_q + RW'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			col_q <= col_eff;
			v_q   <= in_data.drain ? 8'd0 : in_data.pixel;
		end
		if (cmd.load) begin
			gx_q   <= gx_n;
			gy_q   <= gy_n;
			last_q <= last_n;
		end
		if (cmd.square) begin
			sat_q  <= (ax > 17'd255) || (ay > 17'd255);
			sum_q  <= 17'(16'(ax[7:0]) * 16'(ax[7:0])) + 17'(16'(ay[7:0]) * 16'(ay[7:0]));
			root_q <= '0;
			bit_q  <= 3'd7;
		end
		if (cmd.root_step) begin
			if (17'(cand_sq) <= sum_q) root_q <= cand;
			bit_q <= bit_q - 3'd1;
		end
	end

	assign out_data.magnitude = sat_q ? 8'd255 : root_q;
	assign out_data.last      = last_q;
endmodule

FILE: sv/sobel_gradient_magnitude.sv
// Streaming 3x3 gradient magnitude (Sobel, Feldman, Scharr or zero weights) over 8-bit grey
// pixels in raster order; out-of-frame neighbors count as zero and the result is
// floor(sqrt(gx^2+gy^2)) clipped to 255. One request is handled at a time: an item with
// no result passes only a load step; one with a result then passes square, root and output
// steps, the root resolving one result bit per cycle and output waiting out any stall.
// Results lag their pixel by W+1 requests, so send W+1 drain requests after a frame.
// Writing frame_width or frame_height restarts the frame; write registers only when idle.
module sobel_gradient_magnitude #(
	parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sgm_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sgm_pkg::out_item_t         out_data,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [sgm_pkg::CFG_DW-1:0] wr_data
);
	import sgm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sgm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	sgm_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .out_data(out_data),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .cmd(cmd), .sts(sts)
	);

`ifndef NO_ASSERTIONS
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_no_direct_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid) else $error("result too early");
	a_idle_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !in_stall) else $error("not idle after result");
`endif
endmodule
